/* rtl/core/alam_pkg.sv */
// ----------------------------------------------------------------------------
// alam_pkg
// types and fixed constants of the adaptive literal ans model
// ----------------------------------------------------------------------------
package alam_pkg;

    localparam int STATE_W  = 32;
    localparam int LOW_W    = 15;
    localparam int HIGH_W   = STATE_W - LOW_W;
    localparam int SYMBOL_W = 9;
    localparam int BOUND_W  = 16;
    localparam int FREQ_W   = 16;
    localparam int BONUS_W  = 10;

    localparam logic [BONUS_W-1:0] BONUS_RESET = BONUS_W'(725);
    localparam logic [FREQ_W-1:0]  STEP_GAIN   = FREQ_W'(31);
    localparam logic [FREQ_W-1:0]  FREQ_ONE    = FREQ_W'(1);
    localparam int                 BOUND_TOP   = 32'h8000;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_FETCH_LO,
        ST_FETCH_HI,
        ST_MUL,
        ST_FIN,
        ST_AD_RD,
        ST_AD_WR
    } alam_state_t;

endpackage

/* rtl/core/adaptive_literal_ans_model.sv */
// ----------------------------------------------------------------------------
// adaptive_literal_ans_model
// adaptive 15-bit rans literal decoder with periodic bound adaptation
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   in      | sink      | in_valid / in_stall  | coder_state
//   out     | source    | out_valid / out_stall| symbol, next_state
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_data (adapt bonus)
//
// the time one item takes is set by the binary search over the single
// read port of the bound memory
// every ADAPT_PERIOD-th item adds a sweep over both memories
// after reset an initialisation pass loads the bound and frequency memories
// the finished result waits in an output register; a stalled output holds
// the block only when the next result is ready to replace it
// ----------------------------------------------------------------------------
module adaptive_literal_ans_model #(
    parameter int NUM_SYMBOLS    = 300,
    parameter int ADAPT_PERIOD   = 1024,
    parameter int SPREAD_SYMBOLS = 264
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [alam_pkg::STATE_W-1:0]  coder_state,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [alam_pkg::SYMBOL_W-1:0] symbol,
    output logic [alam_pkg::STATE_W-1:0]  next_state,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [alam_pkg::BONUS_W-1:0]  cfg_data
);
    import alam_pkg::*;

    localparam int SA_W  = $clog2(NUM_SYMBOLS);
    localparam int BA_W  = $clog2(NUM_SYMBOLS + 1);
    localparam int SUM_W = FREQ_W + SA_W;
    localparam int CD_W  = $clog2(ADAPT_PERIOD + 1);
    localparam int R_W   = $clog2(2 * SPREAD_SYMBOLS);
    localparam int SPAN  = BOUND_TOP - NUM_SYMBOLS + SPREAD_SYMBOLS;
    localparam int INC_Q = SPAN / SPREAD_SYMBOLS;
    localparam int INC_R = SPAN % SPREAD_SYMBOLS;

    // memories
    logic [BOUND_W-1:0] bound_mem [NUM_SYMBOLS+1];
    logic [FREQ_W-1:0]  freq_mem  [NUM_SYMBOLS];

    logic               b_we;
    logic [BA_W-1:0]    b_waddr;
    logic [BOUND_W-1:0] b_wdata;
    logic [BA_W-1:0]    b_raddr;
    logic [BOUND_W-1:0] b_rdata_reg;
    logic               f_we;
    logic [SA_W-1:0]    f_waddr;
    logic [FREQ_W-1:0]  f_wdata;
    logic [SA_W-1:0]    f_raddr;
    logic [FREQ_W-1:0]  f_rdata_reg;

    // control state
    alam_state_t        state_reg, state_next;
    logic [BA_W-1:0]    idx_reg, idx_next;
    logic [BOUND_W-1:0] q_reg, q_next;
    logic [R_W-1:0]     r_reg, r_next;
    logic [SA_W-1:0]    lo_reg, lo_next;
    logic [SA_W-1:0]    hi_reg, hi_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CD_W-1:0]    cd_reg, cd_next;
    logic [BONUS_W-1:0] bonus_reg;
    logic               out_valid_reg, out_valid_next;

    // payload
    logic [STATE_W-1:0]  st_reg, st_next;
    logic [BOUND_W-1:0]  lo_val_reg, lo_val_next;
    logic [FREQ_W-1:0]   freq_val_reg, freq_val_next;
    logic [STATE_W-1:0]  prod_reg, prod_next;
    logic [SYMBOL_W-1:0] sym_out_reg, sym_out_next;
    logic [STATE_W-1:0]  nxt_out_reg, nxt_out_next;

    logic [SA_W-1:0]    mid;
    logic [R_W-1:0]     r_sum;
    logic [BOUND_W-1:0] init_val;
    logic [STATE_W-1:0] width;
    logic [SUM_W:0]     adapt_acc;
    logic               adapt_now;

    assign mid       = SA_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
    assign r_sum     = r_reg + R_W'(INC_R);
    assign init_val  = (int'(idx_reg) < SPREAD_SYMBOLS) ? q_reg
                     : BOUND_W'(BOUND_TOP - NUM_SYMBOLS) + BOUND_W'(idx_reg);
    assign width     = STATE_W'(b_rdata_reg) - STATE_W'(lo_val_reg);
    assign adapt_now = (cd_reg == CD_W'(1));
    assign sum_next  = sum_reg + SUM_W'(f_rdata_reg);
    assign adapt_acc = (SUM_W + 1)'(b_rdata_reg) + (SUM_W + 1)'(sum_next);

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign symbol     = sym_out_reg;
    assign next_state = nxt_out_reg;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bound_mem[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= bound_mem[b_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
        begin
            freq_mem[f_waddr] <= f_wdata;
        end
        f_rdata_reg <= freq_mem[f_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            q_reg         <= '0;
            r_reg         <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            sum_reg       <= '0;
            cd_reg        <= CD_W'(ADAPT_PERIOD);
            bonus_reg     <= BONUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            sum_reg       <= (state_reg == ST_AD_WR) ? sum_next
                           : (state_reg == ST_FIN) ? '0 : sum_reg;
            cd_reg        <= cd_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                bonus_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg       <= st_next;
        lo_val_reg   <= lo_val_next;
        freq_val_reg <= freq_val_next;
        prod_reg     <= prod_next;
        sym_out_reg  <= sym_out_next;
        nxt_out_reg  <= nxt_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        cd_next        = cd_reg;
        out_valid_next = out_valid_reg;
        st_next        = st_reg;
        lo_val_next    = lo_val_reg;
        freq_val_next  = freq_val_reg;
        prod_next      = prod_reg;
        sym_out_next   = sym_out_reg;
        nxt_out_next   = nxt_out_reg;
        b_we           = 1'b0;
        b_waddr        = idx_reg;
        b_wdata        = init_val;
        b_raddr        = '0;
        f_we           = 1'b0;
        f_waddr        = idx_reg[SA_W-1:0];
        f_wdata        = FREQ_ONE;
        f_raddr        = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT:
            begin
                b_we = 1'b1;
                f_we = (int'(idx_reg) < NUM_SYMBOLS);
                if (r_sum >= R_W'(SPREAD_SYMBOLS))
                begin
                    r_next = r_sum - R_W'(SPREAD_SYMBOLS);
                    q_next = q_reg + BOUND_W'(INC_Q) + BOUND_W'(1);
                end
                else
                begin
                    r_next = r_sum;
                    q_next = q_reg + BOUND_W'(INC_Q);
                end
                if (int'(idx_reg) == NUM_SYMBOLS)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + BA_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    st_next    = coder_state;
                    lo_next    = '0;
                    hi_next    = SA_W'(NUM_SYMBOLS - 1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                b_raddr    = BA_W'(mid) + BA_W'(1);
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if ({1'b0, st_reg[LOW_W-1:0]} < b_rdata_reg)
                begin
                    hi_next = mid;
                end
                else
                begin
                    lo_next = mid + SA_W'(1);
                end
                state_next = (lo_next == hi_next) ? ST_FETCH_LO : ST_SRCH_RD;
            end
            ST_FETCH_LO:
            begin
                b_raddr    = BA_W'(lo_reg);
                f_raddr    = lo_reg;
                state_next = ST_FETCH_HI;
            end
            ST_FETCH_HI:
            begin
                b_raddr       = BA_W'(lo_reg) + BA_W'(1);
                lo_val_next   = b_rdata_reg;
                freq_val_next = f_rdata_reg;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = STATE_W'(st_reg[STATE_W-1:LOW_W] * width);
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    sym_out_next   = SYMBOL_W'(lo_reg);
                    nxt_out_next   = STATE_W'(st_reg[LOW_W-1:0]) + prod_reg
                                   - STATE_W'(lo_val_reg);
                    f_we           = 1'b1;
                    f_waddr        = lo_reg;
                    f_wdata        = freq_val_reg + STEP_GAIN
                                   + (adapt_now ? FREQ_W'(bonus_reg) : '0);
                    idx_next       = '0;
                    if (adapt_now)
                    begin
                        cd_next    = CD_W'(ADAPT_PERIOD);
                        state_next = ST_AD_RD;
                    end
                    else
                    begin
                        cd_next    = cd_reg - CD_W'(1);
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_AD_RD:
            begin
                f_raddr    = idx_reg[SA_W-1:0];
                b_raddr    = idx_reg + BA_W'(1);
                state_next = ST_AD_WR;
            end
            ST_AD_WR:
            begin
                f_we    = 1'b1;
                b_we    = 1'b1;
                b_waddr = idx_reg + BA_W'(1);
                b_wdata = adapt_acc[BOUND_W:1];
                if (int'(idx_reg) == NUM_SYMBOLS - 1)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + BA_W'(1);
                    state_next = ST_AD_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SRCH_RD))
        else $error("accepted item did not start the search");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SRCH_CMP) |-> (lo_reg < hi_reg))
        else $error("search window collapsed before compare");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_FIN))
        else $error("result raised outside the finish step");

    assert property (@(posedge clk) disable iff (!rst_n)
        cd_reg != '0)
        else $error("adaptation countdown reached zero");
`endif

endmodule
